FILE: rtl/rotary_dial_pulse_and_hook_decoder_defines.svh
// Assertion macros shared by the dial decoder RTL.
`ifndef ROTARY_DIAL_PULSE_AND_HOOK_DECODER_DEFINES_SVH
`define ROTARY_DIAL_PULSE_AND_HOOK_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dial decoder check failed");

// Next-cycle implication, checked outside reset.
`define RDP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dial decoder check failed");

`endif

FILE: rtl/rdp_pkg.sv
// Types and constants for the rotary dial pulse and hook decoder.
`default_nettype none

package rdp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned TALLY_W    = 4;

  localparam logic [TALLY_W-1:0] TALLY_MAX = 4'd15;
  localparam logic [TALLY_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [TALLY_W-1:0] DIGIT_TEN = 4'd10;

  localparam logic [9:0]  PULSE_DB_RST  = 10'd10;
  localparam logic [9:0]  HOOK_DB_RST   = 10'd50;
  localparam logic [11:0] FLASH_MIN_RST = 12'd100;
  localparam logic [11:0] FLASH_MAX_RST = 12'd800;
  localparam logic [11:0] DIGIT_GAP_RST = 12'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_DB  = 3'd0,
    REG_HOOK_DB   = 3'd1,
    REG_FLASH_MIN = 3'd2,
    REG_FLASH_MAX = 3'd3,
    REG_DIGIT_GAP = 3'd4
  } cfg_reg_e;

  // Packed lowest field last so the struct maps straight onto tdata bits.
  typedef struct packed {
    logic               line_off_hook;
    logic               flash_seen;
    logic               went_on_hook;
    logic               went_off_hook;
    logic               count_error;
    logic [TALLY_W-1:0] digit_value;
    logic               digit_valid;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/rotary_dial_pulse_and_hook_decoder.sv
// Rotary dial pulse and hook switch decoder: one input beat per millisecond tick,
// one result beat per input beat. Each beat is decoded from the state registers into
// a result register, so a beat is taken every clock cycle as long as the result
// register is empty or being drained in the same cycle; the result is valid in the
// cycle after its beat is taken. Pulses are counted and a digit (or a count error)
// is issued once the configured gap has passed; hook changes are debounced and
// classified as off-hook, flash or hangup. The block starts on hook with the pulse
// and hook counters saturated and the press counter at zero. Registers are written
// by cfg_we_i / cfg_idx_i / cfg_wdata_i and should only change while idle.
`default_nettype none

`include "rotary_dial_pulse_and_hook_decoder_defines.svh"

module rotary_dial_pulse_and_hook_decoder
  import rdp_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // bit 0 pulse_edge, bit 1 hook_edge, bit 2 hook_level_low, bits 7:3 zero
  input  wire logic [7:0]            s_axis_tdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // bit 0 digit_valid, bits 4:1 digit_value, bit 5 count_error,
  // bit 6 went_off_hook, bit 7 went_on_hook, bit 8 flash_seen,
  // bit 9 line_off_hook, bits 15:10 zero
  output logic [15:0]                m_axis_tdata_o,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  // configuration
  logic [9:0]  pulse_db_q, hook_db_q;
  logic [11:0] flash_min_q, flash_max_q, digit_gap_q;

  // decoder state
  logic [TALLY_W-1:0]   tally_q, tally_d;
  logic [TIME_BITS-1:0] since_pulse_q, since_pulse_d;
  logic [TIME_BITS-1:0] since_hook_q, since_hook_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic                 hangup_pend_q, hangup_pend_d;
  logic                 handset_up_q, handset_up_d;

  // result register
  result_t res_q, res_d;
  logic    out_valid_q;

  logic                 accept;
  logic                 pulse_edge, hook_edge, level_low;
  logic [TIME_BITS-1:0] sp_inc, sh_inc, pe_inc;
  logic                 pulse_ok, hook_ok;
  logic [TIME_BITS-1:0] flash_min_ext, flash_max_ext;

  assign pulse_edge = s_axis_tdata_i[0];
  assign hook_edge  = s_axis_tdata_i[1];
  assign level_low  = s_axis_tdata_i[2];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_db_q  <= PULSE_DB_RST;
      hook_db_q   <= HOOK_DB_RST;
      flash_min_q <= FLASH_MIN_RST;
      flash_max_q <= FLASH_MAX_RST;
      digit_gap_q <= DIGIT_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PULSE_DB:  pulse_db_q  <= cfg_wdata_i[9:0];
        REG_HOOK_DB:   hook_db_q   <= cfg_wdata_i[9:0];
        REG_FLASH_MIN: flash_min_q <= cfg_wdata_i;
        REG_FLASH_MAX: flash_max_q <= cfg_wdata_i;
        REG_DIGIT_GAP: digit_gap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign flash_min_ext = TIME_BITS'(flash_min_q);
  assign flash_max_ext = TIME_BITS'(flash_max_q);

  always_comb begin
    // every elapsed counter advances first, saturating
    sp_inc = (since_pulse_q == TimeMax) ? TimeMax : since_pulse_q + 1'b1;
    sh_inc = (since_hook_q == TimeMax) ? TimeMax : since_hook_q + 1'b1;
    pe_inc = (press_q == TimeMax) ? TimeMax : press_q + 1'b1;

    tally_d       = tally_q;
    since_pulse_d = sp_inc;
    since_hook_d  = sh_inc;
    press_d       = pe_inc;
    hangup_pend_d = hangup_pend_q;
    handset_up_d  = handset_up_q;
    res_d         = '0;

    pulse_ok = pulse_edge && (sp_inc > TIME_BITS'(pulse_db_q));
    if (pulse_ok) begin
      if (tally_q != TALLY_MAX) begin
        tally_d = tally_q + 1'b1;
      end
      since_pulse_d = '0;
    end

    hook_ok = hook_edge && (sh_inc > TIME_BITS'(hook_db_q));
    if (hook_ok) begin
      since_hook_d = '0;
      if (!level_low && handset_up_q && !hangup_pend_q) begin
        hangup_pend_d = 1'b1;
        press_d       = '0;
      end else if (level_low && hangup_pend_q) begin
        hangup_pend_d    = 1'b0;
        res_d.flash_seen = (pe_inc >= flash_min_ext) && (pe_inc <= flash_max_ext);
      end else if (level_low && !handset_up_q) begin
        handset_up_d        = 1'b1;
        res_d.went_off_hook = 1'b1;
      end
    end

    // press held past the flash window: a real hangup
    if (hangup_pend_d && (press_d > flash_max_ext)) begin
      hangup_pend_d      = 1'b0;
      handset_up_d       = 1'b0;
      res_d.went_on_hook = 1'b1;
    end

    if ((tally_d != '0) && (since_pulse_d > TIME_BITS'(digit_gap_q))) begin
      if (tally_d <= DIGIT_MAX) begin
        res_d.digit_valid = 1'b1;
        res_d.digit_value = tally_d;
      end else if (tally_d == DIGIT_TEN) begin
        res_d.digit_valid = 1'b1;
      end else begin
        res_d.count_error = 1'b1;
      end
      tally_d = '0;
    end

    res_d.line_off_hook = handset_up_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q       <= '0;
      since_pulse_q <= TimeMax;
      since_hook_q  <= TimeMax;
      press_q       <= '0;
      hangup_pend_q <= 1'b0;
      handset_up_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        tally_q       <= tally_d;
        since_pulse_q <= since_pulse_d;
        since_hook_q  <= since_hook_d;
        press_q       <= press_d;
        hangup_pend_q <= hangup_pend_d;
        handset_up_q  <= handset_up_d;
        out_valid_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  `RDP_ASSERT_IMP(a_pend_needs_up, clk_i, rst_ni, hangup_pend_q, handset_up_q)
  `RDP_ASSERT_IMP(a_digit_or_error, clk_i, rst_ni, out_valid_q,
                  !(res_q.digit_valid && res_q.count_error) && (res_q.digit_value <= DIGIT_MAX))
  `RDP_ASSERT_IMP(a_hook_events, clk_i, rst_ni, out_valid_q,
                  (!res_q.went_off_hook || res_q.line_off_hook) &&
                  (!res_q.went_on_hook || !res_q.line_off_hook))
  `RDP_ASSERT_IMP(a_line_state, clk_i, rst_ni, out_valid_q, res_q.line_off_hook == handset_up_q)
  `RDP_ASSERT_NXT(a_beat_lands, clk_i, rst_ni, accept, out_valid_q)

endmodule

`default_nettype wire

FILE: sim/tb_rotary_dial_pulse_and_hook_decoder.sv
// Self-checking testbench for the rotary dial pulse and hook switch decoder.
`timescale 1ns / 1ps

module tb_rotary_dial_pulse_and_hook_decoder;
  import rdp_pkg::*;

  localparam int unsigned TB_TIME_BITS = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SPAN_CAP     = 24;

  typedef struct packed {
    logic hook_level_low;
    logic hook_edge;
    logic pulse_edge;
  } tick_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic [7:0]            s_data;
  logic                  s_vld;
  logic                  s_axis_tready_o;
  logic [15:0]           m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_rdy;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rotary_dial_pulse_and_hook_decoder #(
    .TIME_BITS(TB_TIME_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_data),
    .s_axis_tvalid_i(s_vld),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_rdy),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Decoder model state and register copies
  logic [9:0]              cfg_pulse_db;
  logic [9:0]              cfg_hook_db;
  logic [11:0]             cfg_flash_min;
  logic [11:0]             cfg_flash_max;
  logic [11:0]             cfg_digit_gap;
  logic [TALLY_W-1:0]      tally;
  logic [TB_TIME_BITS-1:0] since_pulse;
  logic [TB_TIME_BITS-1:0] since_hook;
  logic [TB_TIME_BITS-1:0] press_ms;
  logic                    hangup_pending;
  logic                    handset_up;

  tick_t   tick_queue[$];
  result_t expected_results[$];
  bit      in_taken;
  int      idle_pct, stall_pct;
  int      ticks_queued, beats_in, beats_out, mismatches;
  int      n_digits, n_cnt_err, n_flash, n_onhook, n_offhook;
  int      cycles;
  logic    gen_line_low;

  function automatic logic [TB_TIME_BITS-1:0] sat_inc(input logic [TB_TIME_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic result_t decode_tick(input logic pe, input logic he, input logic lvl);
    result_t r;
    r = '0;
    since_pulse = sat_inc(since_pulse);
    since_hook  = sat_inc(since_hook);
    press_ms    = sat_inc(press_ms);
    if (pe && since_pulse > cfg_pulse_db) begin
      if (tally != TALLY_MAX) tally = tally + 1'b1;
      since_pulse = '0;
    end
    if (he && since_hook > cfg_hook_db) begin
      since_hook = '0;
      if (!lvl && handset_up && !hangup_pending) begin
        hangup_pending = 1'b1;
        press_ms       = '0;
      end else if (lvl && hangup_pending) begin
        hangup_pending = 1'b0;
        if (press_ms >= cfg_flash_min && press_ms <= cfg_flash_max) r.flash_seen = 1'b1;
      end else if (lvl && !handset_up) begin
        handset_up      = 1'b1;
        hangup_pending  = 1'b0;
        r.went_off_hook = 1'b1;
      end
    end
    // press held past the flash window is a real hangup
    if (hangup_pending && press_ms > cfg_flash_max) begin
      hangup_pending = 1'b0;
      handset_up     = 1'b0;
      r.went_on_hook = 1'b1;
    end
    if (tally != '0 && since_pulse > cfg_digit_gap) begin
      if (tally <= DIGIT_MAX) begin
        r.digit_valid = 1'b1;
        r.digit_value = tally;
      end else if (tally == DIGIT_TEN) begin
        r.digit_valid = 1'b1;
      end else begin
        r.count_error = 1'b1;
      end
      tally = '0;
    end
    r.line_off_hook = handset_up;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d of %0d ticks done", cycles, beats_out,
               ticks_queued);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: input beats and output back-pressure change on the falling edge
  always @(negedge clk_i) begin : driver
    tick_t nxt;
    m_rdy <= ($urandom_range(99) >= stall_pct);
    if (!s_vld || in_taken) begin
      if (rst_ni && tick_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = tick_queue.pop_front();
        s_data <= {5'b0, nxt};
        s_vld  <= 1'b1;
      end else begin
        s_vld <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each input beat, checks each output beat
  always @(posedge clk_i) begin : monitor
    result_t got, want;
    in_taken <= rst_ni && s_vld && s_axis_tready_o;
    if (rst_ni) begin
      if (s_vld && s_axis_tready_o) begin
        want = decode_tick(s_data[0], s_data[1], s_data[2]);
        expected_results.push_back(want);
        beats_in++;
        n_digits  += want.digit_valid;
        n_cnt_err += want.count_error;
        n_flash   += want.flash_seen;
        n_onhook  += want.went_on_hook;
        n_offhook += want.went_off_hook;
      end
      if (m_axis_tvalid_o && m_rdy) begin
        got = result_t'(m_axis_tdata_o[9:0]);
        if (expected_results.size() == 0) begin
          $error("result beat %h with nothing expected", m_axis_tdata_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("digit_valid", want.digit_valid, got.digit_valid);
          check_field("digit_value", want.digit_value, got.digit_value);
          check_field("count_error", want.count_error, got.count_error);
          check_field("went_off_hook", want.went_off_hook, got.went_off_hook);
          check_field("went_on_hook", want.went_on_hook, got.went_on_hook);
          check_field("flash_seen", want.flash_seen, got.flash_seen);
          check_field("line_off_hook", want.line_off_hook, got.line_off_hook);
          check_field("tdata_pad", 0, m_axis_tdata_o[15:10]);
          beats_out++;
        end
      end
    end
  end

  task automatic push_tick(input logic pe, input logic he, input logic lvl);
    tick_t t;
    t.pulse_edge     = pe;
    t.hook_edge      = he;
    t.hook_level_low = lvl;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  task automatic push_quiet(input int n);
    repeat (n) push_tick(1'b0, 1'b0, gen_line_low);
  endtask

  function automatic int span(input int v);
    return (v < 0) ? 0 : ((v > SPAN_CAP) ? SPAN_CAP : v);
  endfunction

  // returns at a falling edge with every tick accepted and every result seen
  task automatic wait_drain();
    do @(negedge clk_i);
    while (beats_in != ticks_queued || expected_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_PULSE_DB:  cfg_pulse_db  = val[9:0];
      REG_HOOK_DB:   cfg_hook_db   = val[9:0];
      REG_FLASH_MIN: cfg_flash_min = val[11:0];
      REG_FLASH_MAX: cfg_flash_max = val[11:0];
      REG_DIGIT_GAP: cfg_digit_gap = val[11:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_settings(input int unsigned pdb, input int unsigned hdb,
                               input int unsigned fmin, input int unsigned fmax,
                               input int unsigned gap);
    wait_drain();
    write_reg(REG_PULSE_DB, pdb);
    write_reg(REG_HOOK_DB, hdb);
    write_reg(REG_FLASH_MIN, fmin);
    write_reg(REG_FLASH_MAX, fmax);
    write_reg(REG_DIGIT_GAP, gap);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed dialling and hook activity, with bounce and noise mixed in
  task automatic random_traffic(input int n);
    int start, cnt, k, lo, hi, len;
    start = ticks_queued;
    while (ticks_queued - start < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          cnt = ($urandom_range(3) == 0) ? 10 : $urandom_range(1, 17);
          repeat (cnt) begin
            push_tick(1'b1, 1'b0, gen_line_low);
            if ($urandom_range(3) == 0) push_tick(1'b1, 1'b0, gen_line_low);
            k = span(int'(cfg_pulse_db) + int'($urandom_range(2)) -
                     int'($urandom_range(5) == 0));
            push_quiet(k);
          end
          push_quiet(span(int'(cfg_digit_gap) + $urandom_range(3)));
        end
        4, 5, 6: begin
          if (!gen_line_low) begin
            gen_line_low = 1'b1;
            push_tick(1'b0, 1'b1, 1'b1);
          end else begin
            gen_line_low = 1'b0;
            push_tick(1'b0, 1'b1, 1'b0);
            case ($urandom_range(2))
              0: begin
                hi = int'(cfg_flash_min) - 2;
                lo = (int'(cfg_hook_db) < hi) ? int'(cfg_hook_db) : hi;
                len = (hi < 0) ? 0 : $urandom_range(lo, hi);
              end
              1: begin
                lo = (cfg_flash_min > 0) ? int'(cfg_flash_min) - 1 : 0;
                hi = (cfg_flash_max > 0) ? int'(cfg_flash_max) - 1 : 0;
                if (hi < lo) hi = lo;
                len = $urandom_range(lo, hi);
              end
              default: len = int'(cfg_flash_max) + $urandom_range(3);
            endcase
            push_quiet(span(len));
            gen_line_low = 1'b1;
            push_tick(1'b0, 1'b1, 1'b1);
          end
          push_quiet(span(int'(cfg_hook_db) + 1 + $urandom_range(2)));
        end
        7: begin
          repeat ($urandom_range(1, 6)) begin
            k = $urandom_range(7);
            push_tick(k[0], k[1], k[2]);
          end
        end
        8: push_quiet($urandom_range(1, 20));
        default: begin
          // contact bounce on the hook switch
          repeat ($urandom_range(2, 4)) begin
            gen_line_low = 1'($urandom_range(1));
            push_tick(1'($urandom_range(1)), 1'b1, gen_line_low);
          end
        end
      endcase
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    s_data    = '0;
    s_vld     = 1'b0;
    m_rdy     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_taken  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    cycles    = 0;
    cfg_pulse_db   = PULSE_DB_RST;
    cfg_hook_db    = HOOK_DB_RST;
    cfg_flash_min  = FLASH_MIN_RST;
    cfg_flash_max  = FLASH_MAX_RST;
    cfg_digit_gap  = DIGIT_GAP_RST;
    tally          = '0;
    since_pulse    = '1;
    since_hook     = '1;
    press_ms       = '0;
    hangup_pending = 1'b0;
    handset_up     = 1'b0;
    gen_line_low   = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: tight timing so every event fits in a few ticks
    load_settings(0, 0, 2, 3, 0);
    push_tick(1'b0, 1'b1, 1'b1);               // lift handset
    gen_line_low = 1'b1;
    push_tick(1'b1, 1'b0, 1'b1);               // one pulse, digit 1
    push_tick(1'b0, 1'b0, 1'b1);
    repeat (10) push_tick(1'b1, 1'b0, 1'b1);   // ten pulses give digit 0
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b1, 1'b0);               // press inside the window: flash
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b1, 1'b0);               // too short a press: nothing
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b1, 1'b0);               // held press times out to on hook
    repeat (4) push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b1, 1'b1);               // lift and pulse in one tick
    push_tick(1'b0, 1'b0, 1'b1);

    load_settings(2, 3, 5, 12, 8);
    random_traffic(70);

    load_settings(0, 0, 0, 0, 0);
    idle_pct  = 85;
    random_traffic(50);

    load_settings(1, 2, 3, 20, 6);
    idle_pct  = 0;
    stall_pct = 85;
    random_traffic(70);

    load_settings(1023, 1023, 4095, 4095, 4095);
    idle_pct  = 34;
    stall_pct = 34;
    random_traffic(10);

    // flash window of a single millisecond
    load_settings(5, 1, 10, 10, 3);
    random_traffic(50);

    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d ticks over six register settings and four idling phases",
             beats_out);
    $display("Seen %0d digits, %0d count errors, %0d flashes, %0d hangups, %0d lifts",
             n_digits, n_cnt_err, n_flash, n_onhook, n_offhook);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/rdp_pkg.sv
rtl/rotary_dial_pulse_and_hook_decoder.sv
sim/tb_rotary_dial_pulse_and_hook_decoder.sv
